// ----- rtl/tpr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tpr_pkg;

    // Point slots held in the tracker
    localparam int NUM_PTS = 5;
    localparam int COORD_W = 16;
    localparam int RAW_W   = 32;

    // Stream payload layout
    localparam int STATUS_W  = 8;
    localparam int FLAGS_W   = 8;
    localparam int IN_BITS   = STATUS_W + NUM_PTS * RAW_W;
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 3 + FLAGS_W + NUM_PTS * RAW_W;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int PANEL_W    = 12;

    localparam logic [CFG_IDX_W-1:0] REG_LANDSCAPE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 2'd2;

    localparam logic                 LANDSCAPE_RST    = 1'b1;
    localparam logic [PANEL_W-1:0]   PANEL_WIDTH_RST  = 12'd800;
    localparam logic [PANEL_W-1:0]   PANEL_HEIGHT_RST = 12'd480;

    // Poll counter and decode limits
    localparam int POLL_CNT_W        = 8;
    localparam int MAX_POINTS        = 5;
    localparam int POLL_INTERVAL_DEF = 10;
    localparam int POLL_WRAP         = 240;

    // Flag word bits
    localparam int FLAG_PRESSED_BIT = 7;
    localparam int FLAG_CAUGHT_BIT  = 6;
    localparam int FLAG_SPARE_BIT   = 5;
    localparam int STATUS_READY_BIT = 7;

    localparam logic [FLAGS_W-1:0]  FLAG_KEEP_MASK  = 8'hE0;
    localparam logic [COORD_W-1:0]  COORD_RELEASED  = 16'hFFFF;

    // Output tdata bit positions
    localparam int OB_REPORTED = 0;
    localparam int OB_SAMPLED  = 1;
    localparam int OB_CLEAR    = 2;
    localparam int OB_FLAGS    = 3;

endpackage

`default_nettype wire

// ----- rtl/touch_point_report_tracker_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Touch point report tracker. Each input beat is one poll of a capacitive
// touch controller (status byte plus five raw point records) and yields
// exactly one output beat with the report flags, the tracker flag word and
// the five stored point positions (x in the upper half, y in the lower).
// The block is a two-register pipeline: polls land in an input register,
// one pass of decode logic updates the tracker state and loads the result
// register, which drives the output beat. One poll is accepted every cycle
// while the output side keeps up. While a finished result waits, one more
// poll can be taken into the input register, after which the input stalls
// until the result is taken. Geometry and orientation registers are to be
// written through the cfg port only while the block is idle (the block does
// not enforce this); they take effect on the next poll.

module touch_point_report_tracker_top
#(
    parameter int POLL_INTERVAL = tpr_pkg::POLL_INTERVAL_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // cfg write port
    input  wire logic                         cfg_we,
    input  wire logic [tpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tpr_pkg::CFG_DATA_W-1:0] cfg_data,
    // poll input
    input  wire logic                         s_tvalid,
    output      logic                         s_tready,
    // s_tdata, low bit up: status_byte[7:0], raw_point_0..raw_point_4 (32 each)
    input  wire logic [tpr_pkg::IN_W-1:0]     s_tdata,
    // result output
    output      logic                         m_tvalid,
    input  wire logic                         m_tready,
    // m_tdata, low bit up: touch_reported, status_sampled, status_clear_request,
    // touch_flags[7:0], point_0..point_4 (32 each), zero pad
    output      logic [tpr_pkg::OUT_W-1:0]    m_tdata
);

    import tpr_pkg::*;

    localparam int MOD_W = (POLL_INTERVAL > 1) ? $clog2(POLL_INTERVAL) : 1;
    localparam logic [POLL_CNT_W-1:0] INTERVAL_C = POLL_CNT_W'(POLL_INTERVAL);
    localparam logic [POLL_CNT_W-1:0] WRAP_C     = POLL_CNT_W'(POLL_WRAP);
    localparam logic [MOD_W-1:0]      MOD_LAST   = MOD_W'(POLL_INTERVAL - 1);
    localparam logic [3:0]            MAX_N      = 4'(MAX_POINTS);

    // Configuration registers
    logic                   landscape_reg;
    logic [PANEL_W-1:0]     pwidth_reg;
    logic [PANEL_W-1:0]     pheight_reg;

    // Input register
    logic                   in_vld_reg;
    logic                   in_vld_next;
    logic [STATUS_W-1:0]    in_status_reg;
    logic [RAW_W-1:0]       in_pt_reg [NUM_PTS];

    // Tracker state; mod_reg mirrors poll_count modulo the poll interval
    logic [POLL_CNT_W-1:0]  pc_reg;
    logic [POLL_CNT_W-1:0]  pc_next;
    logic [MOD_W-1:0]       mod_reg;
    logic [MOD_W-1:0]       mod_next;
    logic [FLAGS_W-1:0]     flag_reg;
    logic [FLAGS_W-1:0]     flag_next;
    logic [COORD_W-1:0]     x_reg [NUM_PTS];
    logic [COORD_W-1:0]     x_next [NUM_PTS];
    logic [COORD_W-1:0]     y_reg [NUM_PTS];
    logic [COORD_W-1:0]     y_next [NUM_PTS];

    // Result register
    logic                   out_vld_reg;
    logic                   out_vld_next;
    logic [OUT_W-1:0]       out_data_reg;
    logic [OUT_W-1:0]       out_data_next;

    // Pass signals
    logic                   accept;
    logic                   advance;
    logic [POLL_CNT_W-1:0]  pc_inc;
    logic [MOD_W-1:0]       mod_inc;
    logic                   sampled;
    logic [STATUS_W-1:0]    mode;
    logic [3:0]             npts;
    logic                   clear_req;
    logic                   reported;
    logic                   release_ev;
    logic [NUM_PTS-1:0]     pt_mask;
    logic [COORD_W-1:0]     pw16;
    logic [COORD_W-1:0]     ph16;
    logic [COORD_W-1:0]     first_c;
    logic [COORD_W-1:0]     second_c;
    logic [NUM_PTS*RAW_W-1:0] pts_packed;

    // Handshake: input register drains into the result register
    assign advance     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready    = !in_vld_reg || advance;
    assign accept      = s_tvalid && s_tready;
    assign in_vld_next = accept || (in_vld_reg && !advance);
    assign out_vld_next = advance || (out_vld_reg && !m_tready);

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // Poll counter step and sample decision
    always_comb
    begin
        pc_inc = pc_reg + 1'b1;
        if (pc_inc == '0 || mod_reg == MOD_LAST)
        begin
            mod_inc = '0;
        end
        else
        begin
            mod_inc = mod_reg + 1'b1;
        end
        sampled = (mod_inc == '0) || (pc_inc < INTERVAL_C);
    end

    assign pw16 = {{(COORD_W-PANEL_W){1'b0}}, pwidth_reg};
    assign ph16 = {{(COORD_W-PANEL_W){1'b0}}, pheight_reg};

    // One poll: decode points, bounds check, release handling
    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        flag_next  = flag_reg;
        pc_next    = pc_inc;
        mod_next   = mod_inc;
        first_c    = '0;
        second_c   = '0;
        mode       = sampled ? in_status_reg : '0;
        npts       = mode[3:0];
        clear_req  = mode[STATUS_READY_BIT] && (npts <= MAX_N);
        reported   = (npts != 4'd0) && (npts <= MAX_N);
        release_ev = mode[STATUS_READY_BIT] && (npts == 4'd0);

        for (int k = 0; k < NUM_PTS; k++)
        begin
            pt_mask[k] = (4'(k) < npts);
        end

        if (reported)
        begin
            flag_next = {2'b11, {(FLAGS_W-2-NUM_PTS){1'b0}}, pt_mask};
            x_next[NUM_PTS-1] = x_reg[0];
            y_next[NUM_PTS-1] = y_reg[0];
            for (int k = 0; k < NUM_PTS; k++)
            begin
                if (pt_mask[k])
                begin
                    first_c  = in_pt_reg[k][COORD_W-1:0];
                    second_c = in_pt_reg[k][RAW_W-1:COORD_W];
                    if (landscape_reg)
                    begin
                        y_next[k] = first_c;
                        x_next[k] = pw16 - second_c;
                    end
                    else
                    begin
                        x_next[k] = first_c;
                        y_next[k] = second_c;
                    end
                end
            end

            if (x_next[0] > pw16 || y_next[0] > ph16)
            begin
                if (npts > 4'd1)
                begin
                    // substitute point 1 for an off-panel point 0
                    x_next[0] = x_next[1];
                    y_next[0] = y_next[1];
                    pc_next   = '0;
                    mod_next  = '0;
                end
                else
                begin
                    // lone off-panel point: roll back, then treat as release
                    x_next[0]  = x_reg[0];
                    y_next[0]  = y_reg[0];
                    flag_next  = flag_reg;
                    release_ev = 1'b1;
                end
            end
            else
            begin
                pc_next  = '0;
                mod_next = '0;
            end
        end

        if (release_ev)
        begin
            if (flag_next[FLAG_PRESSED_BIT])
            begin
                flag_next[FLAG_PRESSED_BIT] = 1'b0;
            end
            else
            begin
                x_next[0] = COORD_RELEASED;
                y_next[0] = COORD_RELEASED;
                flag_next = flag_next & FLAG_KEEP_MASK;
            end
        end

        if (pc_next > WRAP_C)
        begin
            pc_next  = INTERVAL_C;
            mod_next = '0;
        end
    end

    // Result packing
    always_comb
    begin
        for (int k = 0; k < NUM_PTS; k++)
        begin
            pts_packed[k*RAW_W +: RAW_W] = {x_next[k], y_next[k]};
        end
        out_data_next = {{(OUT_W-OUT_BITS){1'b0}}, pts_packed, flag_next,
                         clear_req, sampled, reported};
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            landscape_reg <= LANDSCAPE_RST;
            pwidth_reg    <= PANEL_WIDTH_RST;
            pheight_reg   <= PANEL_HEIGHT_RST;
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            pc_reg        <= '0;
            mod_reg       <= '0;
            flag_reg      <= '0;
            for (int k = 0; k < NUM_PTS; k++)
            begin
                x_reg[k] <= '0;
                y_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LANDSCAPE:    landscape_reg <= cfg_data[0];
                    REG_PANEL_WIDTH:  pwidth_reg    <= cfg_data[PANEL_W-1:0];
                    REG_PANEL_HEIGHT: pheight_reg   <= cfg_data[PANEL_W-1:0];
                    default:          ;
                endcase
            end
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
            begin
                pc_reg   <= pc_next;
                mod_reg  <= mod_next;
                flag_reg <= flag_next;
                x_reg    <= x_next;
                y_reg    <= y_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_status_reg <= s_tdata[STATUS_W-1:0];
            for (int k = 0; k < NUM_PTS; k++)
            begin
                in_pt_reg[k] <= s_tdata[STATUS_W + k*RAW_W +: RAW_W];
            end
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tpr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tpr_checker
(
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [tpr_pkg::IN_W-1:0]       s_tdata,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [tpr_pkg::OUT_W-1:0]      m_tdata
);

    import tpr_pkg::*;

    // A stalled result beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // A stalled poll beat is held by the sender
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("poll beat changed while stalled");

    // An unsampled poll cannot report a touch or request a status clear
    a_unsampled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[OB_SAMPLED] |->
            !m_tdata[OB_REPORTED] && !m_tdata[OB_CLEAR])
        else $error("report or clear without a sampled status");

    // The spare flag bit is never set by any update
    a_spare_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[OB_FLAGS + FLAG_SPARE_BIT])
        else $error("spare flag bit set");

    // With no result pending the input side is open
    a_open: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

endmodule

bind touch_point_report_tracker_top tpr_checker u_tpr_checker (.*);

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import tpr_pkg::*;

    localparam int          POLL_IV       = POLL_INTERVAL_DEF;
    localparam logic [7:0]  RELEASE_MASK  = 8'h8F;
    localparam logic [7:0]  RELEASE_CODE  = 8'h80;
    localparam logic [7:0]  PRESS_CATCH   = (8'd1 << FLAG_PRESSED_BIT) | (8'd1 << FLAG_CAUGHT_BIT);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          PHASE_POLLS   = 100;
    localparam int          NUM_PHASES    = 7;

    // Result beat as it sits in m_tdata, low field in the low bits
    typedef struct packed {
        logic [NUM_PTS-1:0][RAW_W-1:0] pts;
        logic [FLAGS_W-1:0]            flags;
        logic                          clear_req;
        logic                          sampled;
        logic                          reported;
    } touch_result_t;

    // Tracker model plus the queue of poll results still to arrive
    class touch_scoreboard;
        bit                 land;
        bit [PANEL_W-1:0]   pw;
        bit [PANEL_W-1:0]   ph;
        bit [7:0]           poll_cnt;
        bit [7:0]           flags;
        bit [COORD_W-1:0]   xs [NUM_PTS];
        bit [COORD_W-1:0]   ys [NUM_PTS];
        touch_result_t      want_q [$];
        int                 errors;
        int                 n_checked;
        int                 n_sampled;
        int                 n_reported;
        int                 n_releases;
        int                 n_cfg;

        function new();
            land = LANDSCAPE_RST;
            pw   = PANEL_WIDTH_RST;
            ph   = PANEL_HEIGHT_RST;
            poll_cnt = '0;
            flags    = '0;
            for (int k = 0; k < NUM_PTS; k++)
            begin
                xs[k] = '0;
                ys[k] = '0;
            end
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            n_cfg++;
            case (idx)
                REG_LANDSCAPE:    land = val[0];
                REG_PANEL_WIDTH:  pw   = val[PANEL_W-1:0];
                REG_PANEL_HEIGHT: ph   = val[PANEL_W-1:0];
                default: ;
            endcase
        endfunction

        // One poll: advance the tracker and queue the result it must produce
        function void note_poll(logic [IN_W-1:0] beat);
            bit [7:0]         mode;
            bit [3:0]         cnt;
            bit [7:0]         saved;
            bit [RAW_W-1:0]   raw;
            bit               smp;
            bit               rep;
            bit               clr;
            touch_result_t    r;
            int               k;
            mode = '0;
            rep  = 1'b0;
            clr  = 1'b0;
            poll_cnt = poll_cnt + 8'd1;
            smp = ((poll_cnt % POLL_IV) == 0) || (poll_cnt < POLL_IV);
            if (smp)
            begin
                mode = beat[STATUS_W-1:0];
                cnt  = mode[3:0];
                if (mode[STATUS_READY_BIT] && cnt <= MAX_POINTS)
                    clr = 1'b1;
                if (cnt >= 1 && cnt <= MAX_POINTS)
                begin
                    saved = flags;
                    flags = PRESS_CATCH | ((8'd1 << cnt) - 8'd1);
                    xs[4] = xs[0];
                    ys[4] = ys[0];
                    for (k = 0; k < NUM_PTS; k++)
                    begin
                        if (flags[k])
                        begin
                            raw = beat[STATUS_W + k*RAW_W +: RAW_W];
                            if (land)
                            begin
                                ys[k] = raw[15:0];
                                xs[k] = {4'b0, pw} - raw[31:16];
                            end
                            else
                            begin
                                xs[k] = raw[15:0];
                                ys[k] = raw[31:16];
                            end
                        end
                    end
                    rep = 1'b1;
                    if (xs[0] > {4'b0, pw} || ys[0] > {4'b0, ph})
                    begin
                        if (cnt > 1)
                        begin
                            // point 0 off panel: take point 1 in its place
                            xs[0] = xs[1];
                            ys[0] = ys[1];
                            poll_cnt = '0;
                        end
                        else
                        begin
                            // lone point off panel: undo and fall into release
                            xs[0] = xs[4];
                            ys[0] = ys[4];
                            mode  = RELEASE_CODE;
                            flags = saved;
                        end
                    end
                    else
                        poll_cnt = '0;
                end
            end
            // Release handling
            if ((mode & RELEASE_MASK) == RELEASE_CODE)
            begin
                n_releases++;
                if (flags[FLAG_PRESSED_BIT])
                    flags[FLAG_PRESSED_BIT] = 1'b0;
                else
                begin
                    xs[0] = COORD_RELEASED;
                    ys[0] = COORD_RELEASED;
                    flags = flags & FLAG_KEEP_MASK;
                end
            end
            if (poll_cnt > POLL_WRAP)
                poll_cnt = POLL_IV;
            if (smp)
                n_sampled++;
            if (rep)
                n_reported++;
            r.reported  = rep;
            r.sampled   = smp;
            r.clear_req = clr;
            r.flags     = flags;
            for (k = 0; k < NUM_PTS; k++)
                r.pts[k] = {xs[k], ys[k]};
            want_q.push_back(r);
        endfunction

        task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= 30)
                $display("MISMATCH result %0d %s: got %h want %h", n_checked, field, got, want);
        endtask

        task check_result(logic [OUT_W-1:0] beat);
            touch_result_t got;
            touch_result_t want;
            int            k;
            got = beat[OUT_BITS-1:0];
            if (want_q.size() == 0)
            begin
                report_mismatch("beat with nothing expected", got.flags, '0);
                return;
            end
            want = want_q.pop_front();
            if (got.reported !== want.reported)
                report_mismatch("touch_reported", got.reported, want.reported);
            if (got.sampled !== want.sampled)
                report_mismatch("status_sampled", got.sampled, want.sampled);
            if (got.clear_req !== want.clear_req)
                report_mismatch("status_clear_request", got.clear_req, want.clear_req);
            if (got.flags !== want.flags)
                report_mismatch("touch_flags", got.flags, want.flags);
            for (k = 0; k < NUM_PTS; k++)
                if (got.pts[k] !== want.pts[k])
                    report_mismatch($sformatf("point_%0d", k), got.pts[k], want.pts[k]);
            if (beat[OUT_W-1:OUT_BITS] !== '0)
                report_mismatch("pad", beat[OUT_W-1:OUT_BITS], '0);
            n_checked++;
        endtask
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;

    touch_scoreboard sb;
    int  cycles    = 0;
    int  n_sent    = 0;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;
    bit  rx_hold_req = 1'b0;

    touch_point_report_tracker_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 clk = ~clk;

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Raw record that decodes inside the current panel, or any 32 bits
    function bit [RAW_W-1:0] gen_point(bit wild);
        bit [15:0] first;
        bit [15:0] second;
        if (wild)
            return $urandom;
        if (sb.land)
        begin
            first  = 16'($urandom_range(0, sb.ph));
            second = 16'($urandom_range(0, sb.pw));
        end
        else
        begin
            first  = 16'($urandom_range(0, sb.pw));
            second = 16'($urandom_range(0, sb.ph));
        end
        return {second, first};
    endfunction

    // Sample both handshakes and config writes at the clock edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.note_poll(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // Result side backpressure
    initial
    begin : rx_side
        int stall;
        stall = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    // One poll beat, with a random gap ahead of it unless tx_steady is set
    task send_poll(input bit [7:0] status, input bit [NUM_PTS-1:0][RAW_W-1:0] raw);
        int g;
        g = tx_steady ? 0 : pick_gap();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tdata  <= {raw, status};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_sent++;
    endtask

    // Stop sending and wait for every queued result
    task drain();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_config(input bit land, input bit [11:0] w, input bit [11:0] h, input bit spare);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LANDSCAPE;
        cfg_data  <= {11'($urandom), land};
        @(posedge clk);
        cfg_index <= REG_PANEL_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= REG_PANEL_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        if (spare)
        begin
            // index past the register list must be ignored
            cfg_index <= REG_UNUSED;
            cfg_data  <= CFG_DATA_W'($urandom);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Touch gesture: presses, release, then some garbage
    task run_gesture();
        bit [NUM_PTS-1:0][RAW_W-1:0] raw;
        bit [7:0] st;
        int       k;
        repeat ($urandom_range(1, 8))
        begin
            st = {($urandom_range(0, 9) != 0), 3'($urandom_range(0, 7)),
                  4'($urandom_range(1, MAX_POINTS))};
            for (k = 0; k < NUM_PTS; k++)
                raw[k] = gen_point($urandom_range(0, 6) == 0);
            send_poll(st, raw);
        end
        repeat ($urandom_range(0, 3))
        begin
            st = {1'b1, 3'($urandom_range(0, 7)), 4'h0};
            for (k = 0; k < NUM_PTS; k++)
                raw[k] = $urandom;
            send_poll(st, raw);
        end
        repeat ($urandom_range(0, 12))
        begin
            for (k = 0; k < NUM_PTS; k++)
                raw[k] = $urandom;
            send_poll(8'($urandom_range(0, 255)), raw);
        end
    endtask

    // Polls with no touch so the poll counter climbs past its wrap point
    task run_quiet(input int count);
        bit [NUM_PTS-1:0][RAW_W-1:0] raw;
        bit [3:0] cnt;
        int       k;
        repeat (count)
        begin
            cnt = ($urandom_range(0, 1) == 0) ? 4'h0 : 4'($urandom_range(MAX_POINTS + 1, 15));
            for (k = 0; k < NUM_PTS; k++)
                raw[k] = $urandom;
            send_poll({1'($urandom), 3'($urandom), cnt}, raw);
        end
    endtask

    initial
    begin : main
        bit [NUM_PTS-1:0][RAW_W-1:0] raw;
        bit          land_tab [NUM_PHASES];
        bit [11:0]   w_tab    [NUM_PHASES];
        bit [11:0]   h_tab    [NUM_PHASES];
        int          p;
        int          start;

        sb = new();
        land_tab = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        w_tab    = '{12'd800, 12'd800, 12'd4095, 12'd1, 12'd1, 12'd4095, 12'd0};
        h_tab    = '{12'd480, 12'd480, 12'd4095, 12'd1, 12'd4095, 12'd1, 12'd0};
        land_tab[6] = 1'($urandom);
        w_tab[6]    = 12'($urandom_range(1, 4095));
        h_tab[6]    = 12'($urandom_range(1, 4095));

        wait (rst_n);
        @(posedge clk);

        // Directed polls at reset geometry (landscape, 800 x 480)
        raw = {32'h0, 32'h0, 32'h0, 32'h0, {16'd200, 16'd100}};
        send_poll(8'h81, raw);
        // five points, edge coordinates, all-ones records
        raw = {32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, {16'd0, 16'd480}, {16'd0, 16'd0}};
        send_poll(8'h85, raw);
        // release while pressed, then release while not pressed
        send_poll(8'h80, raw);
        send_poll(8'h80, raw);
        // point count above the limit
        raw = {5{32'hFFFF_FFFF}};
        send_poll(8'h86, raw);
        send_poll(8'h8F, raw);
        // touch without the ready bit
        raw = {32'h0, 32'h0, 32'h0, {16'd10, 16'd20}, {16'd30, 16'd40}};
        send_poll(8'h03, raw);
        // point 0 off panel with several points
        raw = {32'h0, 32'h0, {16'd5, 16'd6}, {16'd100, 16'd200}, {16'd0, 16'hFFFF}};
        send_poll(8'h83, raw);
        // lone point off panel after mirror underflow
        raw = {32'h0, 32'h0, 32'h0, 32'h0, {16'hFFFF, 16'd10}};
        send_poll(8'h81, raw);
        // lone point off panel without the ready bit
        raw = {32'h0, 32'h0, 32'h0, 32'h0, {16'd0, 16'd481}};
        send_poll(8'h01, raw);
        send_poll(8'hFF, raw);
        send_poll(8'h7F, raw);
        send_poll(8'h40, raw);
        send_poll(8'h00, raw);
        raw = {{16'd800, 16'd480}, {16'd1, 16'd1}, {16'd400, 16'd240},
               {16'd0, 16'd0}, {16'd800, 16'd480}};
        send_poll(8'hC5, raw);
        send_poll(8'h00, raw);
        send_poll(8'h80, raw);
        send_poll(8'h80, raw);
        drain();

        // Randomized phases, one panel setting each
        for (p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            write_config(land_tab[p], w_tab[p], h_tab[p], p == 0);
            rx_steady = (p == 3);
            if (p == 2)
            begin
                // Result side holds off while polls keep coming
                rx_hold_req = 1'b1;
                tx_steady   = 1'b1;
                repeat (6) run_gesture();
            end
            if (p == 1 || p == 5)
                run_quiet(260);
            start = n_sent;
            while (n_sent - start < PHASE_POLLS)
            begin
                tx_steady = (p == 3) || ($urandom_range(0, 7) == 0);
                run_gesture();
            end
            tx_steady = 1'b0;
        end

        drain();
        repeat (10) @(posedge clk);

        $display("Checked %0d poll results over %0d panel settings (%0d config writes).",
                 sb.n_checked, NUM_PHASES + 1, sb.n_cfg);
        $display("Sampled polls %0d, touch reports %0d, releases %0d, mismatches %0d.",
                 sb.n_sampled, sb.n_reported, sb.n_releases, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
